// ----- hw/rtl/idll_pkg.sv -----
// shared constants and types for the linked list engine
package idll_pkg;

   localparam int NodeCountDefault = 64;

   // request codes
   localparam logic [2:0] REQ_INS_HEAD  = 3'd0;
   localparam logic [2:0] REQ_INS_TAIL  = 3'd1;
   localparam logic [2:0] REQ_INS_AFTER = 3'd2;
   localparam logic [2:0] REQ_DELETE    = 3'd3;
   localparam logic [2:0] REQ_SEARCH    = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_BAD_POS   = 2'd3;

   // memory write request from the sequencer
   typedef struct packed {
      logic fwd_we;
      logic bwd_we;
      logic val_we;
   } wr_en_type;

endpackage

// ----- hw/rtl/indexed_doubly_linked_list_engine_top.sv -----
// Linked list engine over a pool of NodeCount nodes held in memories with
// registered reads. After reset a clearing pass rebuilds the free chain, and
// no item is accepted until it ends. One request is served at a time. Tail
// insert, positional insert, delete and search walk the chain node by node,
// each step a link read (S_WALK) followed by evaluation of the read data
// (S_WWAIT). The result is held in an output register, and the next item is
// taken while it waits.
module indexed_doubly_linked_list_engine_top #(
   parameter int NodeCount = idll_pkg::NodeCountDefault,
   localparam int Aw = $clog2(NodeCount),
   localparam int Lw = $clog2(NodeCount + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_item_value,
   input  logic [Lw-1:0]      req_list_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [Aw-1:0]      rsp_node_index
);
   localparam logic [Lw-1:0] Nil = Lw'(NodeCount);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FREAD = 4'd1; // read free head node
   localparam logic [3:0] S_WALK  = 4'd2; // read cur node
   localparam logic [3:0] S_WWAIT = 4'd3; // evaluate cur data
   localparam logic [3:0] S_W1    = 4'd4;
   localparam logic [3:0] S_W2    = 4'd5;
   localparam logic [3:0] S_W3    = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;
   localparam logic [3:0] S_FWAIT = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [31:0]   val_ff, val_in;
   logic [Lw-1:0] pos_ff, pos_in;
   logic [Lw-1:0] head_ff, head_in, free_ff, free_in;
   logic [Lw-1:0] cur_ff, cur_in, cnt_ff, cnt_in;
   logic [Lw-1:0] nfree_ff, nfree_in;   // next of free head
   logic [Lw-1:0] cfwd_ff, cfwd_in, cbwd_ff, cbwd_in;
   logic [1:0]    st_ff, st_in;
   logic [Aw-1:0] idx_ff, idx_in;
   logic          ov_ff, ov_in;
   logic [1:0]    ost_ff, ost_in;
   logic [Aw-1:0] oidx_ff, oidx_in;

   idll_pkg::wr_en_type wr_en;
   logic [Aw-1:0] wr_addr, rd_addr;
   logic [Lw-1:0] wr_fwd, wr_bwd, rd_fwd, rd_bwd, rd_fwd_n, rd_bwd_n;
   logic [31:0]   rd_val;
   logic          init_done;
   logic          fire;

   function automatic logic [Lw-1:0] norm(input logic [Lw-1:0] x);
      return (x < Nil) ? x : Nil;
   endfunction

   idll_mem #(.NodeCount(NodeCount)) u_mem (
      .clock(clock), .reset(reset), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_fwd(wr_fwd), .wr_bwd(wr_bwd), .wr_val(val_ff), .rd_addr(rd_addr),
      .rd_fwd(rd_fwd), .rd_bwd(rd_bwd), .rd_val(rd_val), .init_done(init_done)
   );

   assign rd_fwd_n  = norm(rd_fwd);
   assign rd_bwd_n  = norm(rd_bwd);
   assign req_ready = (state_ff == S_IDLE) && init_done;
   assign fire      = req_valid && req_ready;
   assign rsp_valid      = ov_ff;
   assign rsp_status     = ost_ff;
   assign rsp_node_index = oidx_ff;

   // request sequencer
   always_comb begin
      state_in = state_ff; op_in = op_ff; val_in = val_ff; pos_in = pos_ff;
      head_in = head_ff; free_in = free_ff; cur_in = cur_ff; cnt_in = cnt_ff;
      nfree_in = nfree_ff; cfwd_in = cfwd_ff; cbwd_in = cbwd_ff;
      st_in = st_ff; idx_in = idx_ff;
      ov_in = ov_ff && !rsp_ready; ost_in = ost_ff; oidx_in = oidx_ff;
      wr_en = '0; wr_addr = cur_ff[Aw-1:0]; wr_fwd = Nil; wr_bwd = Nil;
      rd_addr = cur_ff[Aw-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               op_in  = req_type;
               val_in = req_item_value;
               pos_in = (req_list_position == '0) ? Lw'(1) : req_list_position;
               st_in  = idll_pkg::ST_OK;
               idx_in = '0;
               cur_in = head_ff;
               cnt_in = Lw'(1);
               if (req_type <= idll_pkg::REQ_INS_AFTER && free_ff == Nil) begin
                  st_in = idll_pkg::ST_FULL;
                  state_in = S_DONE;
               end else if (req_type > idll_pkg::REQ_SEARCH) begin
                  st_in = idll_pkg::ST_BAD_POS;
                  state_in = S_DONE;
               end else if (req_type <= idll_pkg::REQ_INS_AFTER) begin
                  state_in = S_FREAD;
               end else if (head_ff == Nil) begin
                  st_in = idll_pkg::ST_NOT_FOUND;
                  state_in = S_DONE;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_FREAD: begin
            rd_addr  = free_ff[Aw-1:0];
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            nfree_in = rd_fwd_n;
            idx_in   = free_ff[Aw-1:0];
            if (op_ff == idll_pkg::REQ_INS_HEAD) begin
               state_in = S_W1;
            end else if (head_ff == Nil) begin
               if (op_ff == idll_pkg::REQ_INS_TAIL) begin
                  state_in = S_W1;
               end else begin
                  st_in = idll_pkg::ST_BAD_POS;
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            state_in = S_WWAIT;
         end
         S_WWAIT: begin
            cfwd_in = rd_fwd_n;
            cbwd_in = rd_bwd_n;
            state_in = S_WALK;
            cur_in = rd_fwd_n;
            cnt_in = cnt_ff + Lw'(1);
            priority case (op_ff)
               idll_pkg::REQ_INS_TAIL: begin
                  if (rd_fwd_n == Nil || cnt_ff == Nil) begin
                     cur_in = cur_ff; state_in = S_W1;
                  end
               end
               idll_pkg::REQ_INS_AFTER: begin
                  if (cnt_ff >= pos_ff) begin
                     cur_in = cur_ff; state_in = S_W1;
                  end else if (rd_fwd_n == Nil) begin
                     st_in = idll_pkg::ST_BAD_POS; state_in = S_DONE;
                  end
               end
               default: begin
                  if (rd_val == val_ff) begin
                     cur_in = cur_ff;
                     idx_in = cur_ff[Aw-1:0];
                     state_in = (op_ff == idll_pkg::REQ_DELETE) ? S_W1 : S_DONE;
                  end else if (rd_fwd_n == Nil || cnt_ff == Nil) begin
                     st_in = idll_pkg::ST_NOT_FOUND; state_in = S_DONE;
                  end
               end
            endcase
         end
         S_W1: begin
            state_in = S_W2;
            priority case (op_ff)
               idll_pkg::REQ_INS_HEAD: begin
                  wr_en = '{fwd_we: 1'b1, bwd_we: 1'b1, val_we: 1'b1};
                  wr_addr = idx_ff; wr_fwd = head_ff; wr_bwd = Nil;
                  free_in = nfree_ff;
               end
               idll_pkg::REQ_INS_TAIL: begin
                  wr_en = '{fwd_we: 1'b1, bwd_we: 1'b1, val_we: 1'b1};
                  wr_addr = idx_ff; wr_fwd = Nil;
                  wr_bwd = (head_ff == Nil) ? Nil : cur_ff;
                  free_in = nfree_ff;
                  if (head_ff == Nil) begin
                     head_in = Lw'(idx_ff);
                     state_in = S_DONE;
                  end
               end
               idll_pkg::REQ_INS_AFTER: begin
                  wr_en = '{fwd_we: 1'b1, bwd_we: 1'b1, val_we: 1'b1};
                  wr_addr = idx_ff; wr_fwd = cfwd_ff; wr_bwd = cur_ff;
                  free_in = nfree_ff;
               end
               default: begin
                  // delete: unlink from predecessor or head
                  if (cbwd_ff != Nil) begin
                     wr_en.fwd_we = 1'b1;
                     wr_addr = cbwd_ff[Aw-1:0]; wr_fwd = cfwd_ff;
                  end else begin
                     head_in = cfwd_ff;
                  end
               end
            endcase
         end
         S_W2: begin
            state_in = S_W3;
            priority case (op_ff)
               idll_pkg::REQ_INS_HEAD: begin
                  if (head_ff != Nil) begin
                     wr_en.bwd_we = 1'b1;
                     wr_addr = head_ff[Aw-1:0]; wr_bwd = Lw'(idx_ff);
                  end
                  head_in = Lw'(idx_ff);
                  state_in = S_DONE;
               end
               idll_pkg::REQ_INS_TAIL, idll_pkg::REQ_INS_AFTER: begin
                  wr_en.fwd_we = 1'b1;
                  wr_addr = cur_ff[Aw-1:0]; wr_fwd = Lw'(idx_ff);
                  if (op_ff == idll_pkg::REQ_INS_TAIL) state_in = S_DONE;
               end
               default: begin
                  if (cfwd_ff != Nil) begin
                     wr_en.bwd_we = 1'b1;
                     wr_addr = cfwd_ff[Aw-1:0]; wr_bwd = cbwd_ff;
                  end
               end
            endcase
         end
         S_W3: begin
            state_in = S_DONE;
            if (op_ff == idll_pkg::REQ_INS_AFTER) begin
               if (cfwd_ff != Nil) begin
                  wr_en.bwd_we = 1'b1;
                  wr_addr = cfwd_ff[Aw-1:0]; wr_bwd = Lw'(idx_ff);
               end
            end else begin
               // delete: push node onto free chain
               wr_en.fwd_we = 1'b1; wr_en.bwd_we = 1'b1;
               wr_addr = cur_ff[Aw-1:0]; wr_fwd = free_ff; wr_bwd = Nil;
               free_in = cur_ff;
            end
         end
         S_DONE: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               ost_in = st_ff;
               oidx_in = (st_ff == idll_pkg::ST_OK) ? idx_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= Nil;
         free_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         ov_ff    <= ov_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in; val_ff <= val_in; pos_ff <= pos_in;
      cur_ff <= cur_in; cnt_ff <= cnt_in; nfree_ff <= nfree_in;
      cfwd_ff <= cfwd_in; cbwd_ff <= cbwd_in; st_ff <= st_in; idx_ff <= idx_in;
      ost_ff <= ost_in; oidx_ff <= oidx_in;
   end
endmodule

// ----- hw/rtl/idll_mem.sv -----
// node storage: values, forward links, backward links
module idll_mem #(
   parameter int NodeCount = idll_pkg::NodeCountDefault,
   localparam int Aw = $clog2(NodeCount),
   localparam int Lw = $clog2(NodeCount + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  idll_pkg::wr_en_type wr_en,
   input  logic [Aw-1:0]       wr_addr,
   input  logic [Lw-1:0]       wr_fwd,
   input  logic [Lw-1:0]       wr_bwd,
   input  logic [31:0]         wr_val,
   input  logic [Aw-1:0]       rd_addr,
   output logic [Lw-1:0]       rd_fwd,
   output logic [Lw-1:0]       rd_bwd,
   output logic [31:0]         rd_val,
   output logic                init_done
);
   logic [Lw-1:0] fwd_mem [NodeCount];
   logic [Lw-1:0] bwd_mem [NodeCount];
   logic [31:0]   val_mem [NodeCount];
   logic [Lw-1:0] init_cnt_ff;
   logic [Lw-1:0] init_cnt_in;
   logic          init_run;

   assign init_run    = (init_cnt_ff != Lw'(NodeCount));
   assign init_done   = !init_run;
   assign init_cnt_in = init_run ? init_cnt_ff + Lw'(1) : init_cnt_ff;

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
      end else begin
         init_cnt_ff <= init_cnt_in;
      end
   end

   // forward links: init pass writes i -> i+1
   always_ff @(posedge clock) begin
      if (init_run) begin
         fwd_mem[init_cnt_ff[Aw-1:0]] <= init_cnt_ff + Lw'(1);
      end else if (wr_en.fwd_we) begin
         fwd_mem[wr_addr] <= wr_fwd;
      end
      rd_fwd <= fwd_mem[rd_addr];
   end

   // backward links
   always_ff @(posedge clock) begin
      if (wr_en.bwd_we) begin
         bwd_mem[wr_addr] <= wr_bwd;
      end
      rd_bwd <= bwd_mem[rd_addr];
   end

   // values
   always_ff @(posedge clock) begin
      if (wr_en.val_we) begin
         val_mem[wr_addr] <= wr_val;
      end
      rd_val <= val_mem[rd_addr];
   end
endmodule

// ----- hw/rtl/idll_checker.sv -----
// port-level checks for the linked list engine
module idll_checker #(
   parameter int NodeCount = idll_pkg::NodeCountDefault,
   localparam int Aw = $clog2(NodeCount)
) (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [1:0]    rsp_status,
   input logic [Aw-1:0] rsp_node_index
);
   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_node_index))
      else $error("result changed while stalled");

   // failed request reports index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != idll_pkg::ST_OK |-> rsp_node_index == '0)
      else $error("nonzero index on failure");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // no result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind indexed_doubly_linked_list_engine_top idll_checker #(.NodeCount(NodeCount)) u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_status(rsp_status), .rsp_node_index(rsp_node_index)
);

// ----- tb/tb.sv -----
// self-checking testbench for the indexed doubly linked list engine
`timescale 1ns / 100ps

module tb;

   localparam int NodeCount = 64;
   localparam int Nil = NodeCount;
   localparam int CycleLimit = 1500000;
   localparam int DirectedRows = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_type = idll_pkg::REQ_SEARCH;
   logic signed [31:0] req_item_value = '0;
   logic [6:0] req_list_position = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [5:0] rsp_node_index;

   typedef struct {
      logic [2:0] kind;
      logic [31:0] value;
      logic [6:0] pos;
   } list_req_type;

   typedef struct {
      logic [1:0] status;
      logic [5:0] index;
   } list_rsp_type;

   // shadow copy of the node pool
   logic [31:0] node_value [NodeCount];
   int node_next [NodeCount];
   int node_prev [NodeCount];
   int head_node;
   int free_node;
   int list_len;
   logic [31:0] live_values [$];

   list_rsp_type pending_rsp [$];
   list_req_type directed_rows [DirectedRows];
   logic directed_known [DirectedRows];
   list_rsp_type directed_rsp [DirectedRows];

   int mismatches = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   indexed_doubly_linked_list_engine_top u_top (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_item_value,
      .req_list_position, .rsp_valid, .rsp_ready, .rsp_status, .rsp_node_index
   );

   function automatic int fix_link(int link);
      return (link >= 0 && link < Nil) ? link : Nil;
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < NodeCount; i++) begin
         node_value[i] = '0;
         node_next[i] = i + 1;
         node_prev[i] = Nil;
      end
      head_node = Nil;
      free_node = 0;
      list_len = 0;
      live_values.delete();
   endfunction

   function automatic int find_first(logic [31:0] value);
      int cur;
      int steps;
      cur = fix_link(head_node);
      steps = 0;
      while (cur != Nil && steps < Nil) begin
         if (node_value[cur] == value) return cur;
         cur = fix_link(node_next[cur]);
         steps++;
      end
      return Nil;
   endfunction

   function automatic int pop_free(logic [31:0] value);
      int n;
      n = free_node;
      free_node = fix_link(node_next[n]);
      node_value[n] = value;
      list_len++;
      live_values.push_back(value);
      return n;
   endfunction

   // compute one request's response and update the shadow list
   function automatic list_rsp_type apply_request(list_req_type r);
      list_rsp_type res;
      int n;
      int cur;
      int cnt;
      int pos;
      int after;
      int p;
      int nx;
      res.status = idll_pkg::ST_OK;
      res.index = '0;
      n = Nil;
      if (r.kind <= idll_pkg::REQ_INS_AFTER && free_node == Nil) begin
         res.status = idll_pkg::ST_FULL;
      end else if (r.kind == idll_pkg::REQ_INS_HEAD) begin
         n = pop_free(r.value);
         node_next[n] = head_node;
         node_prev[n] = Nil;
         if (head_node != Nil) node_prev[head_node] = n;
         head_node = n;
      end else if (r.kind == idll_pkg::REQ_INS_TAIL) begin
         n = pop_free(r.value);
         node_next[n] = Nil;
         node_prev[n] = Nil;
         if (head_node == Nil) begin
            head_node = n;
         end else begin
            cur = head_node;
            cnt = 0;
            while (fix_link(node_next[cur]) != Nil && cnt < Nil) begin
               cur = fix_link(node_next[cur]);
               cnt++;
            end
            node_next[cur] = n;
            node_prev[n] = cur;
         end
      end else if (r.kind == idll_pkg::REQ_INS_AFTER) begin
         pos = (r.pos == 0) ? 1 : int'(r.pos);
         cur = head_node;
         cnt = 1;
         while (cur != Nil && cnt < pos) begin
            cur = fix_link(node_next[cur]);
            cnt++;
         end
         if (cur == Nil) begin
            res.status = idll_pkg::ST_BAD_POS;
         end else begin
            n = pop_free(r.value);
            after = fix_link(node_next[cur]);
            node_next[n] = after;
            node_prev[n] = cur;
            node_next[cur] = n;
            if (after != Nil) node_prev[after] = n;
         end
      end else if (r.kind == idll_pkg::REQ_DELETE) begin
         cur = find_first(r.value);
         if (cur == Nil) begin
            res.status = idll_pkg::ST_NOT_FOUND;
         end else begin
            p = fix_link(node_prev[cur]);
            nx = fix_link(node_next[cur]);
            if (p != Nil) node_next[p] = nx;
            else head_node = nx;
            if (nx != Nil) node_prev[nx] = p;
            node_prev[cur] = Nil;
            node_next[cur] = free_node;
            free_node = cur;
            list_len--;
            foreach (live_values[i]) begin
               if (live_values[i] == r.value) begin
                  live_values.delete(i);
                  break;
               end
            end
            n = cur;
         end
      end else if (r.kind == idll_pkg::REQ_SEARCH) begin
         cur = find_first(r.value);
         if (cur == Nil) res.status = idll_pkg::ST_NOT_FOUND;
         else n = cur;
      end else begin
         res.status = idll_pkg::ST_BAD_POS;
      end
      if (res.status == idll_pkg::ST_OK) res.index = n[5:0];
      return res;
   endfunction

   function automatic list_req_type make_req(logic [2:0] kind, logic [31:0] value, int pos);
      list_req_type r;
      r.kind = kind;
      r.value = value;
      r.pos = pos[6:0];
      return r;
   endfunction

   // directed rows: extremes, every request code and the special cases
   initial begin
      list_req_type t [DirectedRows];
      logic [1:0] st [DirectedRows];
      logic [5:0] ix [DirectedRows];
      logic k [DirectedRows];
      t[0]  = make_req(idll_pkg::REQ_SEARCH, 32'h0, 0);
      k[0] = 1'b1; st[0] = idll_pkg::ST_NOT_FOUND; ix[0] = 6'd0;
      t[1]  = make_req(idll_pkg::REQ_DELETE, 32'h7fffffff, 0);
      k[1] = 1'b1; st[1] = idll_pkg::ST_NOT_FOUND; ix[1] = 6'd0;
      t[2]  = make_req(idll_pkg::REQ_INS_AFTER, 32'h5, 0);
      k[2] = 1'b1; st[2] = idll_pkg::ST_BAD_POS; ix[2] = 6'd0;
      t[3]  = make_req(idll_pkg::REQ_INS_TAIL, 32'h80000000, 0);
      k[3] = 1'b1; st[3] = idll_pkg::ST_OK; ix[3] = 6'd0;
      t[4]  = make_req(idll_pkg::REQ_INS_HEAD, 32'h7fffffff, 127);
      k[4] = 1'b1; st[4] = idll_pkg::ST_OK; ix[4] = 6'd1;
      t[5]  = make_req(idll_pkg::REQ_INS_AFTER, 32'hffffffff, 0);  k[5] = 1'b0;
      t[6]  = make_req(idll_pkg::REQ_INS_AFTER, 32'h1, 3);         k[6] = 1'b0;
      t[7]  = make_req(idll_pkg::REQ_INS_AFTER, 32'h2, 5);
      k[7] = 1'b1; st[7] = idll_pkg::ST_BAD_POS; ix[7] = 6'd0;
      t[8]  = make_req(idll_pkg::REQ_INS_AFTER, 32'h3, 64);
      k[8] = 1'b1; st[8] = idll_pkg::ST_BAD_POS; ix[8] = 6'd0;
      t[9]  = make_req(idll_pkg::REQ_INS_AFTER, 32'h3, 127);
      k[9] = 1'b1; st[9] = idll_pkg::ST_BAD_POS; ix[9] = 6'd0;
      t[10] = make_req(idll_pkg::REQ_INS_TAIL, 32'h7fffffff, 0);   k[10] = 1'b0;
      t[11] = make_req(idll_pkg::REQ_SEARCH, 32'h7fffffff, 0);     k[11] = 1'b0;
      t[12] = make_req(idll_pkg::REQ_DELETE, 32'h7fffffff, 0);     k[12] = 1'b0;
      t[13] = make_req(idll_pkg::REQ_SEARCH, 32'h7fffffff, 0);     k[13] = 1'b0;
      t[14] = make_req(idll_pkg::REQ_SEARCH, 32'h80000000, 0);     k[14] = 1'b0;
      t[15] = make_req(3'd5, 32'h1, 1);
      k[15] = 1'b1; st[15] = idll_pkg::ST_BAD_POS; ix[15] = 6'd0;
      t[16] = make_req(3'd6, 32'hffffffff, 64);
      k[16] = 1'b1; st[16] = idll_pkg::ST_BAD_POS; ix[16] = 6'd0;
      t[17] = make_req(3'd7, 32'h0, 127);
      k[17] = 1'b1; st[17] = idll_pkg::ST_BAD_POS; ix[17] = 6'd0;
      t[18] = make_req(idll_pkg::REQ_DELETE, 32'h80000000, 0);     k[18] = 1'b0;
      t[19] = make_req(idll_pkg::REQ_DELETE, 32'h1, 0);            k[19] = 1'b0;
      t[20] = make_req(idll_pkg::REQ_DELETE, 32'hffffffff, 0);     k[20] = 1'b0;
      t[21] = make_req(idll_pkg::REQ_DELETE, 32'h7fffffff, 0);     k[21] = 1'b0;
      t[22] = make_req(idll_pkg::REQ_DELETE, 32'h7fffffff, 0);
      k[22] = 1'b1; st[22] = idll_pkg::ST_NOT_FOUND; ix[22] = 6'd0;
      t[23] = make_req(idll_pkg::REQ_INS_AFTER, 32'h9, 1);
      k[23] = 1'b1; st[23] = idll_pkg::ST_BAD_POS; ix[23] = 6'd0;
      for (int i = 0; i < DirectedRows; i++) begin
         directed_rows[i] = t[i];
         directed_known[i] = k[i];
         directed_rsp[i].status = st[i];
         directed_rsp[i].index = ix[i];
      end
   end

   // compare one response with the oldest expectation
   task automatic check_rsp();
      list_rsp_type want;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response status=%0d index=%0d", rsp_status, rsp_node_index);
      end else begin
         want = pending_rsp.pop_front();
         if (want.status !== rsp_status || want.index !== rsp_node_index) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status=%0d index=%0d, got status=%0d index=%0d",
                        want.status, want.index, rsp_status, rsp_node_index);
         end
      end
   endtask

   // receiver: random stalls, checks on each accepted item
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_rsp();
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4 && live_values.size() > 0)
         return live_values[$urandom_range(live_values.size() - 1)];
      if (sel < 7) return 32'($urandom_range(15)) - 32'd8;
      return $urandom;
   endfunction

   // random request, biased toward the list length given by phase_target
   function automatic list_req_type random_req(int phase_target);
      int sel;
      logic [2:0] kind;
      int pos;
      sel = $urandom_range(99);
      if (sel < 2) kind = 3'($urandom_range(7, 5));
      else if (list_len < phase_target) kind = (sel < 40) ? idll_pkg::REQ_INS_HEAD :
                                               (sel < 65) ? idll_pkg::REQ_INS_TAIL :
                                               (sel < 85) ? idll_pkg::REQ_INS_AFTER :
                                               (sel < 93) ? idll_pkg::REQ_SEARCH :
                                               idll_pkg::REQ_DELETE;
      else kind = (sel < 15) ? idll_pkg::REQ_INS_HEAD :
                  (sel < 25) ? idll_pkg::REQ_INS_TAIL :
                  (sel < 35) ? idll_pkg::REQ_INS_AFTER :
                  (sel < 70) ? idll_pkg::REQ_DELETE : idll_pkg::REQ_SEARCH;
      if ($urandom_range(9) == 0) pos = $urandom_range(127);
      else pos = $urandom_range(list_len + 1);
      return make_req(kind, pick_value(), pos);
   endfunction

   // drive one item and record its expectation at acceptance
   task automatic send_req(list_req_type r, logic known, list_rsp_type fixed);
      list_rsp_type want;
      // idle gap: valid drops only when the sender waits
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_item_value <= r.value;
      req_list_position <= r.pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = apply_request(r);
      if (known && (want.status !== fixed.status || want.index !== fixed.index))
         want = fixed;
      pending_rsp.push_back(want);
   endtask

   initial begin
      list_rsp_type none;
      int target;
      none.status = idll_pkg::ST_OK;
      none.index = '0;
      clear_pool();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part with fixed sender and receiver idling
      send_idle_pct = 35;
      recv_idle_pct = 84;
      for (int i = 0; i < DirectedRows; i++)
         send_req(directed_rows[i], directed_known[i], directed_rsp[i]);

      // random part in three idling phases; fill to full in the middle one
      for (int i = 0; i < 1150; i++) begin
         if (i == 380) begin
            send_idle_pct = 84;
            recv_idle_pct = 35;
         end
         if (i == 760) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         target = (i >= 500 && i < 650) ? 70 : (i % 300 < 150 ? 40 : 8);
         send_req(random_req(target), 1'b0, none);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
